// ===== design/apc_pkg.sv =====
// ----------------------------------------------------------------------------
// Arm position controller package
// Shared widths, constants, mode codes and payload types of the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apc_pkg;

  // Width of a potentiometer reading.
  localparam int PositionBits = 12;
  // Width of a drive speed register.
  localparam int SpeedBits    = 8;
  // Width of the signed drive value.
  localparam int DriveBits    = 9;
  // Width of the divider numerator: speed times distance.
  localparam int DivNumBits   = PositionBits + SpeedBits;

  // The slow-down band is a tenth of the span; the idle band a fortieth,
  // which is the slow-down band divided by four.
  localparam int DecelDiv     = 10;
  localparam int StopShift    = 2;
  localparam int IdleDrive    = 10;

  // A tenth is taken as a multiply by the reciprocal and a shift, exact for
  // spans of up to 16 bits.
  localparam int DecelRecip   = 52429;
  localparam int DecelShift   = 19;

  // Register reset values.
  localparam logic [31:0] LowReset   = 32'd100;
  localparam logic [31:0] HighReset  = 32'd2250;
  localparam logic [31:0] UpReset    = 32'd128;
  localparam logic [31:0] DownReset  = 32'd64;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LOW_POSITION  = 2'd0,
    REG_HIGH_POSITION = 2'd1,
    REG_UP_SPEED      = 2'd2,
    REG_DOWN_SPEED    = 2'd3
  } reg_index_t;

  // Arm operating modes as reported on the output.
  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2,
    MODE_AUTO = 2'd3
  } mode_t;

  // One control tick.
  typedef struct packed {
    logic                    toggle_button;
    logic                    up_button;
    logic                    down_button;
    logic [PositionBits-1:0] arm_position;
  } in_t;

  // One result.
  typedef struct packed {
    logic signed [DriveBits-1:0] arm_drive;
    mode_t                       arm_mode;
  } out_t;

endpackage

`default_nettype wire

// ===== design/apc_div.sv =====
// ----------------------------------------------------------------------------
// Arm position controller divider
// Restoring shift-subtract divider, one quotient bit per cycle, with a
// programmable number of iterations for left-aligned short numerators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apc_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 12,
  localparam int CNT_W = $clog2(NUM_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [CNT_W-1:0] iters,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] count;
  logic             busy;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One step: bring the next numerator bit into the remainder and try
  // to subtract the divisor.
  always_comb begin
    shifted = {rem, acc[NUM_W-1]};
    diff    = shifted - {1'b0, den};
    fits    = (shifted >= {1'b0, den});
  end

  // Iteration control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc   <= num;
        rem   <= '0;
        count <= iters;
        busy  <= 1'b1;
      end else if (busy) begin
        acc   <= {acc[NUM_W-2:0], fits};
        rem   <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = acc;

endmodule

`default_nettype wire

// ===== design/arm_position_controller.sv =====
// Sequence: a manual or stop tick is accepted in S_IDLE and its result is registered
// in S_OUT once the output is free; an automatic tick passes S_SPAN, S_MUL, S_SCALE and
// S_SCALE_WAIT, one pass through the bit-serial divider (speed*dist/decel), then S_OUT.
// Flow: one tick at a time; the next is taken once the result is in the output
// register, which may wait.
// Reset: synchronous, active high; registers return to their defaults, stop.
// ----------------------------------------------------------------------------
// Arm position controller
// Toggle, manual and automatic arm drive with deceleration near the target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arm_position_controller
  import apc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire in_t                     in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output out_t                         out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire reg_index_t              cfg_index,
  input  wire logic [PositionBits-1:0] cfg_data
);

  localparam int CntBits   = $clog2(DivNumBits + 1);
  localparam int RecipBits = PositionBits + DecelShift;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_MUL,
    S_SCALE,
    S_SCALE_WAIT,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PositionBits-1:0] low_position;
  logic [PositionBits-1:0] high_position;
  logic [SpeedBits-1:0]    up_speed;
  logic [SpeedBits-1:0]    down_speed;

  // Controller state.
  logic                        toggle_prev;
  mode_t                       mode_reg;
  logic                        target_valid;
  logic [PositionBits-1:0]     target_position;
  logic signed [DriveBits-1:0] drive_reg;

  // Automatic drive working registers.
  logic [PositionBits-1:0] pos;
  logic [PositionBits-1:0] mag;
  logic                    neg;
  logic [SpeedBits-1:0]    speed_mag;
  logic [PositionBits-1:0] decel;
  logic [DivNumBits-1:0]   prod;

  // Combinational helpers.
  logic [PositionBits:0]   mid_sum;
  logic [PositionBits-1:0] mid;
  logic                    toggle_rise;
  logic                    target_valid_next;
  logic [PositionBits-1:0] target_position_next;
  logic [PositionBits:0]   span;
  logic [PositionBits-1:0] span_pos;
  logic [RecipBits-1:0]    decel_prod;
  logic [PositionBits:0]   delta;
  logic [PositionBits:0]   delta_neg;
  logic [PositionBits-1:0] stop_band;
  logic [SpeedBits-1:0]    scaled;
  logic [SpeedBits-1:0]    auto_mag;
  logic                    auto_neg;
  logic                    in_beat;

  // Divider interface.
  logic                  div_start;
  logic [DivNumBits-1:0] div_num;
  logic [PositionBits-1:0] div_den;
  logic [CntBits-1:0]    div_iters;
  logic                  div_done;
  logic [DivNumBits-1:0] div_quot;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;

  // Toggle handling: aim at the end away from the current position.
  always_comb begin
    mid_sum     = {1'b0, low_position} + {1'b0, high_position};
    mid         = mid_sum[PositionBits:1];
    toggle_rise = in_data.toggle_button && !toggle_prev;
    if (toggle_rise) begin
      target_valid_next    = 1'b1;
      target_position_next = (in_data.arm_position > mid) ? low_position : high_position;
    end else begin
      target_valid_next    = target_valid;
      target_position_next = target_position;
    end
  end

  // Span, distance and the final choice of automatic drive.
  always_comb begin
    span       = {1'b0, high_position} - {1'b0, low_position};
    span_pos   = span[PositionBits] ? '0 : span[PositionBits-1:0];
    decel_prod = RecipBits'(span_pos) * RecipBits'(DecelRecip);
    delta      = {1'b0, target_position} - {1'b0, pos};
    delta_neg  = -delta;
    stop_band  = decel >> StopShift;
    scaled     = div_quot[SpeedBits-1:0];
    if (mag < stop_band) begin
      auto_mag = SpeedBits'(IdleDrive);
      auto_neg = (target_position == low_position);
    end else if (mag < decel) begin
      auto_mag = scaled;
      auto_neg = neg;
    end else begin
      auto_mag = speed_mag;
      auto_neg = neg;
    end
  end

  // The divider serves the speed scaling over the full numerator width.
  assign div_start = (state == S_SCALE);
  assign div_num   = prod;
  assign div_den   = decel;
  assign div_iters = CntBits'(DivNumBits);

  apc_div #(
    .NUM_W (DivNumBits),
    .DEN_W (PositionBits)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_position  <= LowReset[PositionBits-1:0];
      high_position <= HighReset[PositionBits-1:0];
      up_speed      <= UpReset[SpeedBits-1:0];
      down_speed    <= DownReset[SpeedBits-1:0];
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_POSITION:  low_position  <= cfg_data;
        REG_HIGH_POSITION: high_position <= cfg_data;
        REG_UP_SPEED:      up_speed      <= cfg_data[SpeedBits-1:0];
        REG_DOWN_SPEED:    down_speed    <= cfg_data[SpeedBits-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      toggle_prev     <= 1'b0;
      mode_reg        <= MODE_STOP;
      target_valid    <= 1'b0;
      target_position <= '0;
      drive_reg       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            pos             <= in_data.arm_position;
            toggle_prev     <= in_data.toggle_button;
            target_position <= target_position_next;
            target_valid    <= target_valid_next;
            state           <= S_OUT;
            if (in_data.up_button) begin
              if (mode_reg != MODE_UP) begin
                drive_reg    <= DriveBits'(up_speed);
                target_valid <= 1'b0;
                mode_reg     <= MODE_UP;
              end
            end else if (in_data.down_button) begin
              if (mode_reg != MODE_DOWN) begin
                drive_reg    <= -DriveBits'(down_speed);
                target_valid <= 1'b0;
                mode_reg     <= MODE_DOWN;
              end
            end else if (target_valid_next) begin
              mode_reg <= MODE_AUTO;
              state    <= S_SPAN;
            end else if (mode_reg != MODE_STOP) begin
              drive_reg <= '0;
              mode_reg  <= MODE_STOP;
            end
          end
        end
        S_SPAN: begin
          neg       <= delta[PositionBits];
          mag       <= delta[PositionBits] ? delta_neg[PositionBits-1:0]
                                           : delta[PositionBits-1:0];
          speed_mag <= delta[PositionBits] ? down_speed : up_speed;
          decel     <= decel_prod[DecelShift +: PositionBits];
          state     <= S_MUL;
        end
        S_MUL: begin
          prod  <= DivNumBits'(speed_mag) * DivNumBits'(mag);
          state <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_SCALE_WAIT;
        end
        S_SCALE_WAIT: begin
          if (div_done) begin
            drive_reg <= auto_neg ? -DriveBits'(auto_mag) : DriveBits'(auto_mag);
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.arm_drive <= drive_reg;
            out_data.arm_mode  <= mode_reg;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/apc_checker.sv =====
// ----------------------------------------------------------------------------
// Arm position controller checker
// Port-level assertions on the controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apc_checker
  import apc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Every accepted tick leaves the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // Stop mode always reports zero drive.
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.arm_mode == MODE_STOP) |-> (out_data.arm_drive == 0))
    else $error("stop mode with non-zero drive");

  // Manual modes drive in their own direction only.
  a_manual_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !((out_data.arm_mode == MODE_UP) && (out_data.arm_drive < 0)) &&
                  !((out_data.arm_mode == MODE_DOWN) && (out_data.arm_drive > 0)))
    else $error("manual drive in the wrong direction");

endmodule

bind arm_position_controller apc_checker u_apc_checker (.*);

`default_nettype wire
